@@ sv/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the shadowed-compare PWM timer.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int PTS_COUNTER_WIDTH = 32;
    localparam int PTS_NUM_CHANNELS  = 6;
    localparam int PTS_OUT_W         = 6;
    localparam int PTS_DATA_W        = 32;
    localparam int PTS_CFG_IW        = 2;

    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_WR_DUTY   = 3'd1;
    localparam logic [2:0] ACT_RD_DUTY   = 3'd2;
    localparam logic [2:0] ACT_WR_COUNT  = 3'd3;
    localparam logic [2:0] ACT_RD_COUNT  = 3'd4;

    localparam logic [PTS_CFG_IW-1:0] CFG_PRESCALE = 2'd0;
    localparam logic [PTS_CFG_IW-1:0] CFG_PERIOD   = 2'd1;
    localparam logic [PTS_CFG_IW-1:0] CFG_RUN      = 2'd2;
    localparam logic [PTS_CFG_IW-1:0] CFG_OE_MASK  = 2'd3;

    typedef struct packed {
        logic [2:0]            action;
        logic [2:0]            channel;
        logic [PTS_DATA_W-1:0] value;
    } pts_in_t;

    typedef struct packed {
        logic [PTS_OUT_W-1:0]  pwm_out;
        logic [PTS_DATA_W-1:0] read_value;
        logic                  period_wrap;
        logic                  bad_channel;
        logic [PTS_OUT_W-1:0]  latch_waiting;
    } pts_out_t;

    typedef struct packed {
        logic [PTS_DATA_W-1:0] prescale;
        logic [PTS_DATA_W-1:0] period;
        logic                  run_enable;
        logic [PTS_OUT_W-1:0]  oe_mask;
    } pts_cfg_t;

endpackage

@@ sv/pts_in_if.sv @@
// ----------------------------------------------------------------------------
// pts_in_if
// Input word channel: action, channel, value with valid/ready.
// ----------------------------------------------------------------------------
interface pts_in_if import pts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [2:0]            action;
    logic [2:0]            channel;
    logic [PTS_DATA_W-1:0] value;

    modport source (output valid, output action, output channel, output value,
                    input ready);
    modport sink   (input valid, input action, input channel, input value,
                    output ready);
endinterface

@@ sv/pts_out_if.sv @@
// ----------------------------------------------------------------------------
// pts_out_if
// Result word channel of the PWM timer with valid/ready.
// ----------------------------------------------------------------------------
interface pts_out_if import pts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PTS_OUT_W-1:0]  pwm_out;
    logic [PTS_DATA_W-1:0] read_value;
    logic                  period_wrap;
    logic                  bad_channel;
    logic [PTS_OUT_W-1:0]  latch_waiting;

    modport source (output valid, output pwm_out, output read_value,
                    output period_wrap, output bad_channel, output latch_waiting,
                    input ready);
    modport sink   (input valid, input pwm_out, input read_value,
                    input period_wrap, input bad_channel, input latch_waiting,
                    output ready);
endinterface

@@ sv/pwm_timer_shadow_match.sv @@
// ----------------------------------------------------------------------------
// pwm_timer_shadow_match
// Six-channel PWM timer with prescaler and shadowed duty compares that load
// on period wrap; bus words read and write duty and counter.
// ----------------------------------------------------------------------------
//  port     | dir | handshake        | word
//  ---------+-----+------------------+------------------------------------------
//  in       | in  | valid/ready      | action, channel, value
//  out      | out | valid/ready      | pwm_out, read_value, period_wrap,
//           |     |                  | bad_channel, latch_waiting
//  cfg_*    | in  | cfg_we only      | cfg_index, cfg_data
//
//  One word per cycle sustained while out is ready; a word passes the input
//  register, then the state update into the result register.
//  Reset clears all configuration and timer state; no clearing pass.
//  A stall on out holds the result register; the input register keeps
//  accepting until it too is full.
// ----------------------------------------------------------------------------
module pwm_timer_shadow_match import pts_pkg::*;
#(
    parameter int COUNTER_WIDTH = PTS_COUNTER_WIDTH,
    parameter int NUM_CHANNELS  = PTS_NUM_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    pts_in_if.sink                in,
    pts_out_if.source             out,
    input  logic                  cfg_we,
    input  logic [PTS_CFG_IW-1:0] cfg_index,
    input  logic [PTS_DATA_W-1:0] cfg_data
);

    pts_cfg_t cfg;
    pts_in_t  in_word_reg;
    logic     in_valid_reg;
    pts_out_t out_word_reg;
    logic     out_valid_reg;
    pts_out_t res;
    logic     step;
    logic     in_take;

    assign step    = in_valid_reg && (!out_valid_reg || out.ready);
    assign in_take = in.valid && in.ready;

    assign in.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg.action  <= in.action;
            in_word_reg.channel <= in.channel;
            in_word_reg.value   <= in.value;
        end
        if (step)
            out_word_reg <= res;
    end

    pts_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pts_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .NUM_CHANNELS  (NUM_CHANNELS)
    ) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .word  (in_word_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign out.valid         = out_valid_reg;
    assign out.pwm_out       = out_word_reg.pwm_out;
    assign out.read_value    = out_word_reg.read_value;
    assign out.period_wrap   = out_word_reg.period_wrap;
    assign out.bad_channel   = out_word_reg.bad_channel;
    assign out.latch_waiting = out_word_reg.latch_waiting;

endmodule

@@ sv/pts_cfg.sv @@
// ----------------------------------------------------------------------------
// pts_cfg
// Configuration register file: prescale, period, run enable, output mask.
// ----------------------------------------------------------------------------
module pts_cfg import pts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [PTS_CFG_IW-1:0] cfg_index,
    input  logic [PTS_DATA_W-1:0] cfg_data,
    output pts_cfg_t              cfg
);

    pts_cfg_t cfg_reg;
    pts_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRESCALE: cfg_next.prescale   = cfg_data;
                CFG_PERIOD:   cfg_next.period     = cfg_data;
                CFG_RUN:      cfg_next.run_enable = cfg_data[0];
                CFG_OE_MASK:  cfg_next.oe_mask    = cfg_data[PTS_OUT_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/pts_core.sv @@
// ----------------------------------------------------------------------------
// pts_core
// Timer state (prescaler, counter, shadow and active compares) and the
// combinational update that forms one result word per input word.
// ----------------------------------------------------------------------------
module pts_core import pts_pkg::*;
#(
    parameter int COUNTER_WIDTH = PTS_COUNTER_WIDTH,
    parameter int NUM_CHANNELS  = PTS_NUM_CHANNELS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  pts_in_t  word,
    input  pts_cfg_t cfg,
    output pts_out_t res
);

    localparam int CMP_W  = (COUNTER_WIDTH > PTS_DATA_W) ? COUNTER_WIDTH : PTS_DATA_W;
    localparam int OUT_CH = (NUM_CHANNELS < PTS_OUT_W) ? NUM_CHANNELS : PTS_OUT_W;

    logic [PTS_DATA_W-1:0]    prescale_count_reg;
    logic [PTS_DATA_W-1:0]    prescale_count_next;
    logic [COUNTER_WIDTH-1:0] timer_count_reg;
    logic [COUNTER_WIDTH-1:0] timer_count_next;
    logic [PTS_DATA_W-1:0]    shadow_duty_reg  [NUM_CHANNELS];
    logic [PTS_DATA_W-1:0]    shadow_duty_next [NUM_CHANNELS];
    logic [PTS_DATA_W-1:0]    active_duty_reg  [NUM_CHANNELS];
    logic [PTS_DATA_W-1:0]    active_duty_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]  latch_pending_reg;
    logic [NUM_CHANNELS-1:0]  latch_pending_next;

    logic                     chan_valid;
    logic [PTS_DATA_W-1:0]    shadow_sel;
    logic [PTS_DATA_W-1:0]    rd;
    logic                     wrap;
    logic                     bad;

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        timer_count_next    = timer_count_reg;
        shadow_duty_next    = shadow_duty_reg;
        active_duty_next    = active_duty_reg;
        latch_pending_next  = latch_pending_reg;
        rd   = '0;
        wrap = 1'b0;
        bad  = 1'b0;

        chan_valid = (word.channel != 3'd0) && (int'(word.channel) <= NUM_CHANNELS);
        shadow_sel = '0;
        for (int n = 0; n < NUM_CHANNELS; n++)
        begin
            if (int'(word.channel) == n + 1)
                shadow_sel = shadow_duty_reg[n];
        end

        case (word.action)
            ACT_TICK:
            begin
                if (cfg.run_enable)
                begin
                    if (prescale_count_reg >= cfg.prescale)
                    begin
                        prescale_count_next = '0;
                        if (CMP_W'(timer_count_reg) == CMP_W'(cfg.period))
                        begin
                            timer_count_next = '0;
                            for (int n = 0; n < NUM_CHANNELS; n++)
                            begin
                                if (latch_pending_reg[n])
                                    active_duty_next[n] = shadow_duty_reg[n];
                            end
                            latch_pending_next = '0;
                            wrap = 1'b1;
                        end
                        else
                        begin
                            timer_count_next = timer_count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        prescale_count_next = prescale_count_reg + 1'b1;
                    end
                end
            end
            ACT_WR_DUTY:
            begin
                if (chan_valid)
                begin
                    for (int n = 0; n < NUM_CHANNELS; n++)
                    begin
                        if (int'(word.channel) == n + 1)
                        begin
                            shadow_duty_next[n]   = word.value;
                            latch_pending_next[n] = 1'b1;
                        end
                    end
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            ACT_RD_DUTY:
            begin
                if (word.channel == 3'd0)
                    rd = cfg.period;
                else if (chan_valid)
                    rd = shadow_sel;
                else
                    bad = 1'b1;
            end
            ACT_WR_COUNT:
            begin
                timer_count_next = COUNTER_WIDTH'(CMP_W'(word.value));
            end
            ACT_RD_COUNT:
            begin
                rd = PTS_DATA_W'(CMP_W'(timer_count_reg));
            end
            default:
            begin
                rd = '0;
            end
        endcase

        res = '0;
        res.read_value  = rd;
        res.period_wrap = wrap;
        res.bad_channel = bad;
        for (int n = 0; n < OUT_CH; n++)
        begin
            res.pwm_out[n] = cfg.oe_mask[n]
                && (CMP_W'(timer_count_next) < CMP_W'(active_duty_next[n]));
            res.latch_waiting[n] = latch_pending_next[n];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            timer_count_reg    <= '0;
            latch_pending_reg  <= '0;
            for (int n = 0; n < NUM_CHANNELS; n++)
            begin
                shadow_duty_reg[n] <= '0;
                active_duty_reg[n] <= '0;
            end
        end
        else if (step)
        begin
            prescale_count_reg <= prescale_count_next;
            timer_count_reg    <= timer_count_next;
            latch_pending_reg  <= latch_pending_next;
            shadow_duty_reg    <= shadow_duty_next;
            active_duty_reg    <= active_duty_next;
        end
    end

    a_wrap_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.period_wrap |=> latch_pending_reg == '0)
        else $error("pending latches survived a period wrap");

    a_bad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.bad_channel |-> res.read_value == '0 && !res.period_wrap)
        else $error("bad channel word carries data or wrap");

    a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && word.action == ACT_TICK && !cfg.run_enable
        |=> $stable(timer_count_reg) && $stable(prescale_count_reg))
        else $error("stopped timer advanced");

endmodule
